[rtl/gre_pkg.sv]
package gre_pkg;
	localparam logic [0:0] REG_PAINT_ALPHA = 1'b0;

	// round(x * y / 255)
	function automatic logic [7:0] mul255(input logic [7:0] x, input logic [7:0] y);
		logic [16:0] t;
		logic [16:0] u;
		t = {1'b0, 16'(x) * 16'(y)} + 17'd128;
		u = t + {8'd0, t[16:8]};
		return u[15:8];
	endfunction
endpackage

[rtl/gre_div.sv]
// Restoring divider of an unsigned NUM_BITS-bit magnitude by a 9-bit positive divisor.
// Pipelined one quotient bit per stage; NUM_BITS stages in total.
module gre_div import gre_pkg::*; #(
	parameter int NUM_BITS = 24,
	parameter int TAG_W = 8
) (
	input  logic clk,
	input  logic adv,
	input  logic [NUM_BITS-1:0] mag,
	input  logic [8:0] den,
	input  logic [TAG_W-1:0] tag_in,
	output logic [NUM_BITS-1:0] quo,
	output logic [TAG_W-1:0] tag_out
);
	logic [NUM_BITS-1:0] num_s [NUM_BITS+1];
	logic [9:0] rem_s [NUM_BITS+1];
	logic [8:0] den_s [NUM_BITS+1];
	logic [TAG_W-1:0] tag_s [NUM_BITS+1];

	assign num_s[0] = mag;
	assign rem_s[0] = '0;
	assign den_s[0] = den;
	assign tag_s[0] = tag_in;

	// advance one quotient bit per stage
	for (genvar i = 0; i < NUM_BITS; i++) begin : g_st
		logic [10:0] trial;
		logic [10:0] diff;
		assign trial = {rem_s[i], num_s[i][NUM_BITS-1]};
		assign diff = trial - {2'd0, den_s[i]};
		always_ff @(posedge clk) begin
			if (adv) begin
				den_s[i+1] <= den_s[i];
				tag_s[i+1] <= tag_s[i];
				if (!diff[10]) begin
					rem_s[i+1] <= diff[9:0];
					num_s[i+1] <= {num_s[i][NUM_BITS-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= trial[9:0];
					num_s[i+1] <= {num_s[i][NUM_BITS-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = num_s[NUM_BITS];
	assign tag_out = tag_s[NUM_BITS];
endmodule

[rtl/gradient_ramp_entry.sv]
// Channel     | Direction | Handshake
// in item     | input     | in_valid / in_stall
// out item    | output    | out_valid / out_stall
// config      | APB write | psel, penable, pwrite, pready
// One item per cycle unless the output stalls. Stages: alpha scale, 24-stage
// step divider, multiply, sum, premultiply. Reset clears valid bits and sets
// paint_alpha to 255. A stall at the output freezes the whole pipeline.
module gradient_ramp_entry import gre_pkg::*; #(
	parameter int TABLE_LENGTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [0:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_stall,
	input  logic [31:0] start_color,
	input  logic [31:0] end_color,
	input  logic [8:0] segment_length,
	input  logic [7:0] entry_index,
	output logic out_valid,
	input  logic out_stall,
	output logic [31:0] plain_pixel,
	output logic [31:0] dithered_pixel
);
	localparam int DEPTH = 24;
	localparam logic [8:0] TLEN = 9'(TABLE_LENGTH > 511 ? 511 : TABLE_LENGTH);

	logic [7:0] paint_alpha_q;
	logic adv;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign pready = 1'b1;
	assign prdata = {24'd0, paint_alpha_q};

	// hold the paint alpha register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paint_alpha_q <= 8'hFF;
		end else if (psel && penable && pwrite && paddr == REG_PAINT_ALPHA) begin
			paint_alpha_q <= pwdata[7:0];
		end
	end

	// stage 1: saturate length and index, scale alphas
	logic v_s1;
	logic [31:0] s_s1, e_s1;
	logic [8:0] span_s1;
	logic [7:0] idx_s1;
	logic [8:0] len_c;
	assign len_c = (segment_length > TLEN) ? TLEN : segment_length;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			s_s1 <= {mul255(start_color[31:24], paint_alpha_q), start_color[23:0]};
			e_s1 <= {mul255(end_color[31:24], paint_alpha_q), end_color[23:0]};
			if (len_c < 9'd2) begin
				span_s1 <= 9'd0;
				idx_s1 <= 8'd0;
			end else begin
				span_s1 <= len_c - 9'd1;
				idx_s1 <= ({1'b0, entry_index} >= len_c) ? 8'(len_c - 9'd1) : entry_index;
			end
		end
	end

	// four dividers, one per channel; tag carries the start value, index, sign and zero-span flag
	localparam int TAG_W = 8 + 8 + 1 + 1;
	logic [DEPTH-1:0] q [4];
	logic [TAG_W-1:0] tg [4];
	for (genvar c = 0; c < 4; c++) begin : g_ch
		logic [8:0] d;
		logic [DEPTH:0] num;
		logic [DEPTH-1:0] mag;
		assign d = {1'b0, e_s1[c*8+:8]} - {1'b0, s_s1[c*8+:8]};
		assign num = {d, 16'd0};
		assign mag = num[DEPTH] ? DEPTH'(-num) : num[DEPTH-1:0];
		gre_div #(.NUM_BITS(DEPTH), .TAG_W(TAG_W)) u_div (
			.clk(clk), .adv(adv), .mag(mag),
			.den(span_s1 == 9'd0 ? 9'd1 : span_s1),
			.tag_in({s_s1[c*8+:8], idx_s1, num[DEPTH], span_s1 == 9'd0}),
			.quo(q[c]), .tag_out(tg[c])
		);
	end

	logic v_d [DEPTH+1];
	assign v_d[0] = v_s1;
	for (genvar i = 0; i < DEPTH; i++) begin : g_v
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_d[i+1] <= 1'b0;
			else if (adv) v_d[i+1] <= v_d[i];
		end
	end

	// stage 2: signed step times index
	logic v_s2;
	logic signed [33:0] prod_s2 [4];
	logic [7:0] st_s2 [4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_d[DEPTH];
	end
	for (genvar c = 0; c < 4; c++) begin : g_m
		logic signed [25:0] stp;
		assign stp = tg[c][0] ? 26'sd0 :
			(tg[c][1] ? -$signed({2'b0, q[c]}) : $signed({2'b0, q[c]}));
		always_ff @(posedge clk) begin
			if (adv) begin
				prod_s2[c] <= stp * $signed({1'b0, tg[c][9:2]});
				st_s2[c] <= tg[c][17:10];
			end
		end
	end

	// stage 3: sum and take channel plus dither
	logic v_s3;
	logic [7:0] pl_s3 [4];
	logic [7:0] dt_s3 [4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	for (genvar c = 0; c < 4; c++) begin : g_s
		logic [33:0] val;
		logic [15:0] n;
		logic [16:0] dn;
		assign val = 34'($signed({2'b0, st_s2[c], 16'h8000}) + prod_s2[c]);
		assign n = val[23:8];
		if (c == 3) begin : g_up
			assign dn = {n, 1'b0} - {1'b0, (n | {8'd0, n[15:8]})};
		end else begin : g_dn
			assign dn = {n, 1'b0} - {1'b0, n[15:8], n[15:8]};
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				pl_s3[c] <= val[23:16];
				dt_s3[c] <= dn[15:8];
			end
		end
	end

	// stage 4: premultiply
	logic v_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			plain_pixel <= {pl_s3[3], mul255(pl_s3[2], pl_s3[3]),
				mul255(pl_s3[1], pl_s3[3]), mul255(pl_s3[0], pl_s3[3])};
			dithered_pixel <= {dt_s3[3], mul255(dt_s3[2], dt_s3[3]),
				mul255(dt_s3[1], dt_s3[3]), mul255(dt_s3[0], dt_s3[3])};
		end
	end
	assign out_valid = v_s4;
endmodule

[rtl/gre_checker.sv]
module gre_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [31:0] plain_pixel,
	input logic pready
);
	// stall input only while output is stalled
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall)) else $error("input stall without output stall");
	// held output stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(plain_pixel)))
		else $error("stalled output changed");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind gradient_ramp_entry gre_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .plain_pixel(plain_pixel),
	.pready(pready)
);
